// ===== design/mau_pkg.sv =====
// mau_pkg: types, constants and sequencer states of the modular arithmetic unit
// no dependencies; used by modular_arithmetic_unit
package mau_pkg;

    localparam int VALUE_BITS = 31;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [VALUE_BITS:0]   wide_t;
    typedef logic [2:0]            opcode_t;

    localparam value_t RESET_MODULUS = value_t'(1000000007);

    localparam opcode_t OP_ADD = 3'd0;
    localparam opcode_t OP_SUB = 3'd1;
    localparam opcode_t OP_MUL = 3'd2;
    localparam opcode_t OP_DIV = 3'd3;
    localparam opcode_t OP_POW = 3'd4;

    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    typedef struct packed {
        opcode_t operation;
        value_t  operand_a;
        value_t  operand_b;
    } command_t;

    typedef struct packed {
        value_t result_value;
        logic   no_inverse;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_MUL_DBL,
        S_MUL_ADD,
        S_MUL_DONE,
        S_POW_CHK,
        S_POW_ACC,
        S_POW_SQ,
        S_EUC_START,
        S_EUC_DIV,
        S_EUC_ADD,
        S_EUC_UPD,
        S_DIV_FIN,
        S_DONE
    } state_t;

endpackage

// ===== design/modular_arithmetic_unit.sv =====
// modular_arithmetic_unit: add, subtract, multiply, divide and power modulo a register
// depends on mau_pkg
//
// channel   direction  handshake                 word
// cmd       in         start & !busy             command (operation, operand_a, operand_b)
// result    out        done, one cycle strobe    result (result_value, no_inverse)
// cfg       in         cfg_we                    cfg_data: modulus
//
// operands are first reduced bit by bit by the shared long division step, then
// compare-subtract steps do the rest: add/subtract in the dispatch state, a modular
// multiply by a double and an add per multiplier bit, power up to 62 multiplies
// (square and multiply), divide by euclid rounds (one long division each) plus one multiply.
// reset loads the modulus 1000000007; busy stays high until done pulses.
// the receiver cannot stall: done is high for one cycle only; result holds until the next command is taken.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  command_t command,
    output logic     busy,
    output logic     done,
    output result_t  result,
    input  logic     cfg_we,
    input  value_t   cfg_data
);

    state_t             state_reg, state_next, ret_reg, ret_next;
    value_t             modulus_reg;
    opcode_t            op_reg, op_next;
    value_t             a_reg, a_next, b_reg, b_next;
    value_t             sh_reg, sh_next, rem_reg, rem_next;
    value_t             mx_reg, mx_next, my_reg, my_next, macc_reg, macc_next;
    value_t             pacc_reg, pacc_next, sq_reg, sq_next, e_reg, e_next;
    value_t             r0_reg, r0_next, r1_reg, r1_next, s0_reg, s0_next, s1_reg, s1_next;
    logic               qbit_reg, qbit_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    value_t             res_reg, res_next;
    logic               flag_reg, flag_next;

    // (x + y) mod m for x, y below m
    function automatic value_t add_mod(value_t x, value_t y, value_t m);
        wide_t s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[VALUE_BITS-1:0];
    endfunction

    // shared long division step: shift in one dividend bit, compare, subtract
    value_t div_sel;
    wide_t  rem_sh;
    logic   rem_ge;
    value_t rem_step;
    assign div_sel  = (state_reg == S_EUC_DIV) ? r1_reg : modulus_reg;
    assign rem_sh   = {rem_reg, sh_reg[VALUE_BITS-1]};
    assign rem_ge   = rem_sh >= {1'b0, div_sel};
    assign rem_step = rem_ge ? VALUE_BITS'(rem_sh - {1'b0, div_sel})
                             : rem_sh[VALUE_BITS-1:0];

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= RESET_MODULUS;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_data;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        macc_reg <= macc_next;
        pacc_reg <= pacc_next;
        sq_reg   <= sq_next;
        e_reg    <= e_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        qbit_reg <= qbit_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
    end

    // next state and datapath control
    always_comb
    begin
        wide_t t;
        state_next = state_reg;
        ret_next   = ret_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        macc_next  = macc_reg;
        pacc_next  = pacc_reg;
        sq_next    = sq_reg;
        e_next     = e_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        qbit_next  = qbit_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        flag_next  = flag_reg;
        t          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = command.operation;
                    b_next    = command.operand_b;
                    sh_next   = command.operand_a;
                    rem_next  = '0;
                    cnt_next  = CNT_LAST;
                    res_next  = '0;
                    flag_next = 1'b0;
                    if (modulus_reg < value_t'(2) || command.operation > OP_POW)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RED_A;
                    end
                end
            end
            // reduce operand a, then operand b
            S_RED_A:
            begin
                rem_next = rem_step;
                sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    a_next     = rem_step;
                    sh_next    = b_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_LAST;
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                rem_next = rem_step;
                sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    b_next     = rem_step;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        res_next   = add_mod(a_reg, b_reg, modulus_reg);
                        state_next = S_DONE;
                    end
                    OP_SUB:
                    begin
                        if (a_reg >= b_reg)
                        begin
                            res_next = a_reg - b_reg;
                        end
                        else
                        begin
                            t        = {1'b0, a_reg} + {1'b0, modulus_reg} - {1'b0, b_reg};
                            res_next = t[VALUE_BITS-1:0];
                        end
                        state_next = S_DONE;
                    end
                    OP_MUL:
                    begin
                        mx_next    = a_reg;
                        my_next    = b_reg;
                        macc_next  = '0;
                        cnt_next   = CNT_LAST;
                        ret_next   = S_MUL_DONE;
                        state_next = S_MUL_DBL;
                    end
                    OP_DIV:
                    begin
                        r0_next    = b_reg;
                        r1_next    = modulus_reg;
                        s0_next    = value_t'(1);
                        s1_next    = '0;
                        state_next = S_EUC_START;
                    end
                    default:
                    begin
                        pacc_next  = value_t'(1);
                        sq_next    = a_reg;
                        e_next     = b_reg;
                        state_next = S_POW_CHK;
                    end
                endcase
            end
            // shared modular multiply, multiplier bits msb first
            S_MUL_DBL:
            begin
                macc_next  = add_mod(macc_reg, macc_reg, modulus_reg);
                state_next = S_MUL_ADD;
            end
            S_MUL_ADD:
            begin
                if (my_reg[VALUE_BITS-1])
                begin
                    macc_next = add_mod(macc_reg, mx_reg, modulus_reg);
                end
                my_next  = {my_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = S_MUL_DBL;
                end
            end
            S_MUL_DONE:
            begin
                res_next   = macc_reg;
                state_next = S_DONE;
            end
            // square and multiply, exponent lsb first
            S_POW_CHK:
            begin
                cnt_next  = CNT_LAST;
                macc_next = '0;
                if (e_reg == '0)
                begin
                    res_next   = pacc_reg;
                    state_next = S_DONE;
                end
                else if (e_reg[0])
                begin
                    mx_next    = pacc_reg;
                    my_next    = sq_reg;
                    ret_next   = S_POW_ACC;
                    state_next = S_MUL_DBL;
                end
                else
                begin
                    mx_next    = sq_reg;
                    my_next    = sq_reg;
                    ret_next   = S_POW_SQ;
                    state_next = S_MUL_DBL;
                end
            end
            S_POW_ACC:
            begin
                pacc_next  = macc_reg;
                mx_next    = sq_reg;
                my_next    = sq_reg;
                macc_next  = '0;
                cnt_next   = CNT_LAST;
                ret_next   = S_POW_SQ;
                state_next = S_MUL_DBL;
            end
            S_POW_SQ:
            begin
                sq_next    = macc_reg;
                e_next     = {1'b0, e_reg[VALUE_BITS-1:1]};
                state_next = S_POW_CHK;
            end
            // extended euclid, cofactors kept modulo the modulus
            S_EUC_START:
            begin
                cnt_next = CNT_LAST;
                if (r1_reg == '0)
                begin
                    if (r0_reg == value_t'(1))
                    begin
                        mx_next    = a_reg;
                        my_next    = s0_reg;
                        macc_next  = '0;
                        ret_next   = S_DIV_FIN;
                        state_next = S_MUL_DBL;
                    end
                    else
                    begin
                        res_next   = '0;
                        flag_next  = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    rem_next   = '0;
                    sh_next    = r0_reg;
                    macc_next  = '0;
                    state_next = S_EUC_DIV;
                end
            end
            S_EUC_DIV:
            begin
                rem_next   = rem_step;
                sh_next    = {sh_reg[VALUE_BITS-2:0], 1'b0};
                qbit_next  = rem_ge;
                macc_next  = add_mod(macc_reg, macc_reg, modulus_reg);
                state_next = S_EUC_ADD;
            end
            S_EUC_ADD:
            begin
                if (qbit_reg)
                begin
                    macc_next = add_mod(macc_reg, s1_reg, modulus_reg);
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_EUC_UPD;
                end
                else
                begin
                    state_next = S_EUC_DIV;
                end
            end
            S_EUC_UPD:
            begin
                r0_next = r1_reg;
                r1_next = rem_reg;
                s0_next = s1_reg;
                if (s0_reg >= macc_reg)
                begin
                    s1_next = s0_reg - macc_reg;
                end
                else
                begin
                    t       = {1'b0, s0_reg} + {1'b0, modulus_reg} - {1'b0, macc_reg};
                    s1_next = t[VALUE_BITS-1:0];
                end
                state_next = S_EUC_START;
            end
            S_DIV_FIN:
            begin
                res_next   = macc_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    assign busy                = (state_reg != S_IDLE);
    assign done                = (state_reg == S_DONE);
    assign result.result_value = res_reg;
    assign result.no_inverse   = flag_reg;

endmodule

// ===== tb/tb_modular_arithmetic_unit.sv =====
// tb_modular_arithmetic_unit: self-checking testbench for the modular arithmetic unit
// a directed table at the reset modulus, then random words over several moduli
// depends on mau_pkg and modular_arithmetic_unit
`timescale 1ns / 100ps

module tb_modular_arithmetic_unit;
    import mau_pkg::*;

    localparam int  MAX_CYCLES = 30_000_000;
    localparam int  TAIL_CYCLES = 200;
    localparam int  DIRECTED_ROWS = 22;
    localparam int  NUM_MODULI = 8;

    logic     clk;
    logic     rst_n;
    logic     start;
    command_t command;
    logic     busy;
    logic     done;
    result_t  result;
    logic     cfg_we;
    value_t   cfg_data;

    // modulus as the block should hold it
    value_t   cur_modulus;
    result_t  pending_results[$];
    int       mismatches;
    int       cycle_count;
    logic     any_fail;

    // one row of the directed table
    typedef struct {
        opcode_t operation;
        value_t  operand_a;
        value_t  operand_b;
        logic    typed;
        value_t  want_value;
        logic    want_flag;
    } stim_row_t;

    stim_row_t directed[DIRECTED_ROWS];
    value_t    moduli[NUM_MODULI];

    modular_arithmetic_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // (x * y) mod m on 64-bit integers
    function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                                longint unsigned m);
        mul_mod = (x * y) % m;
    endfunction

    // inverse of x mod m by extended euclid; ok low when gcd is not 1
    function automatic longint unsigned inverse_mod(longint unsigned x, longint unsigned m,
                                                    output logic ok);
        longint r_prev, r_cur, s_prev, s_cur, q, tmp;
        r_prev = longint'(x);
        r_cur  = longint'(m);
        s_prev = 1;
        s_cur  = 0;
        while (r_cur != 0)
        begin
            q      = r_prev / r_cur;
            tmp    = r_prev - q * r_cur;
            r_prev = r_cur;
            r_cur  = tmp;
            tmp    = s_prev - q * s_cur;
            s_prev = s_cur;
            s_cur  = tmp;
        end
        ok = (r_prev == 1);
        s_prev = s_prev % longint'(m);
        if (s_prev < 0)
            s_prev = s_prev + longint'(m);
        inverse_mod = ok ? longint'(s_prev) : 0;
    endfunction

    // expected result word for a command word under the given modulus
    function automatic result_t modular_result(command_t cmd, value_t modulus);
        longint unsigned m, a, b, acc, sq, e, inv;
        logic    ok;
        result_t r;
        r = '0;
        m = modulus;
        if (m >= 2)
        begin
            a = longint'(cmd.operand_a) % m;
            b = longint'(cmd.operand_b) % m;
            case (cmd.operation)
                OP_ADD: r.result_value = value_t'((a + b) % m);
                OP_SUB: r.result_value = value_t'((a >= b) ? (a - b) : (a + m - b));
                OP_MUL: r.result_value = value_t'(mul_mod(a, b, m));
                OP_DIV:
                begin
                    inv = inverse_mod(b, m, ok);
                    if (ok)
                        r.result_value = value_t'(mul_mod(a, inv, m));
                    else
                        r.no_inverse = 1'b1;
                end
                OP_POW:
                begin
                    acc = 1;
                    sq  = a;
                    e   = b;
                    while (e != 0)
                    begin
                        if (e[0])
                            acc = mul_mod(acc, sq, m);
                        sq = mul_mod(sq, sq, m);
                        e  = e >> 1;
                    end
                    r.result_value = value_t'(acc);
                end
                default: r = '0;
            endcase
        end
        modular_result = r;
    endfunction

    // random idle length: mostly short, a few long
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 7)
            idle_length = $urandom_range(0, 2);
        else
            idle_length = $urandom_range(10, 60);
    endfunction

    // issue one command word; called at the edge that accepted the previous word
    task automatic issue_command(command_t cmd, logic typed, result_t typed_result);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        // wait for the edge that takes the word
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(typed ? typed_result : modular_result(cmd, cur_modulus));
    endtask

    // wait until the block is idle and every result has come, then write the modulus
    task automatic write_modulus(value_t value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_modulus = value;
    endtask

    // random command word shaped for the current modulus
    function automatic command_t random_command(value_t modulus);
        command_t cmd;
        int       sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            cmd.operation = opcode_t'($urandom_range(5, 7));
        else
            cmd.operation = opcode_t'($urandom_range(0, 4));
        if (modulus >= 2 && $urandom_range(0, 9) < 8)
        begin
            cmd.operand_a = value_t'($urandom() % modulus);
            cmd.operand_b = value_t'($urandom() % modulus);
        end
        else
        begin
            cmd.operand_a = value_t'($urandom());
            cmd.operand_b = value_t'($urandom());
        end
        // edge operands now and then
        sel = $urandom_range(0, 15);
        if (sel == 0)
            cmd.operand_b = '0;
        else if (sel == 1)
            cmd.operand_a = (modulus >= 1) ? modulus - 1'b1 : '1;
        else if (sel == 2)
            cmd.operand_b = '1;
        random_command = cmd;
    endfunction

    // result checker: each strobe word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result word: value %0d flag %0b",
                             result.result_value, result.no_inverse);
            end
            else
            begin
                if (result.result_value !== pending_results[0].result_value ||
                    result.no_inverse !== pending_results[0].no_inverse)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result mismatch: expected value %0d flag %0b, got %0d %0b",
                                 pending_results[0].result_value,
                                 pending_results[0].no_inverse,
                                 result.result_value, result.no_inverse);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        command_t cmd;
        result_t  typed_res;
        int       n;
        int       k;

        start       <= 1'b0;
        command     <= '0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        cur_modulus = RESET_MODULUS;

        // directed rows; typed expectations only where obvious
        directed[0]  = '{OP_ADD, 31'd0, 31'd0, 1'b1, 31'd0, 1'b0};
        directed[1]  = '{OP_ADD, 31'd1000000006, 31'd1, 1'b1, 31'd0, 1'b0};
        directed[2]  = '{OP_SUB, 31'd0, 31'd1, 1'b1, 31'd1000000006, 1'b0};
        directed[3]  = '{OP_SUB, 31'd5, 31'd5, 1'b1, 31'd0, 1'b0};
        directed[4]  = '{OP_MUL, 31'd1000000006, 31'd0, 1'b1, 31'd0, 1'b0};
        directed[5]  = '{OP_MUL, 31'd1000000006, 31'd1000000006, 1'b1, 31'd1, 1'b0};
        directed[6]  = '{OP_DIV, 31'd12345, 31'd0, 1'b1, 31'd0, 1'b1};
        directed[7]  = '{OP_DIV, 31'd12345, 31'd1, 1'b1, 31'd12345, 1'b0};
        directed[8]  = '{OP_DIV, 31'd1000000006, 31'd1000000006, 1'b1, 31'd1, 1'b0};
        directed[9]  = '{OP_DIV, 31'd7, 31'd3, 1'b0, 31'd0, 1'b0};
        directed[10] = '{OP_POW, 31'd1000000006, 31'd0, 1'b1, 31'd1, 1'b0};
        directed[11] = '{OP_POW, 31'd0, 31'd0, 1'b1, 31'd1, 1'b0};
        directed[12] = '{OP_POW, 31'd2, 31'd1000000006, 1'b1, 31'd1, 1'b0};
        directed[13] = '{OP_POW, 31'h7fffffff, 31'h7fffffff, 1'b0, 31'd0, 1'b0};
        directed[14] = '{opcode_t'(5), 31'd9, 31'd9, 1'b1, 31'd0, 1'b0};
        directed[15] = '{opcode_t'(6), 31'h7fffffff, 31'h7fffffff, 1'b1, 31'd0, 1'b0};
        directed[16] = '{opcode_t'(7), 31'd1, 31'd1, 1'b1, 31'd0, 1'b0};
        // operands not below the modulus
        directed[17] = '{OP_ADD, 31'h7fffffff, 31'h7fffffff, 1'b0, 31'd0, 1'b0};
        directed[18] = '{OP_SUB, 31'd1000000007, 31'h7fffffff, 1'b0, 31'd0, 1'b0};
        directed[19] = '{OP_DIV, 31'd3, 31'd1000000007, 1'b1, 31'd0, 1'b1};
        // increment and decrement
        directed[20] = '{OP_ADD, 31'd41, 31'd1, 1'b1, 31'd42, 1'b0};
        directed[21] = '{OP_SUB, 31'd0, 31'd1, 1'b1, 31'd1000000006, 1'b0};

        // moduli walked by the random part, extremes and below-two cases included
        moduli[0] = 31'd2;
        moduli[1] = 31'h7fffffff;
        moduli[2] = 31'd12;
        moduli[3] = 31'd0;
        moduli[4] = 31'd1;
        moduli[5] = 31'd3600;
        moduli[6] = 31'd0;
        moduli[7] = RESET_MODULUS;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset modulus
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            cmd.operation           = directed[k].operation;
            cmd.operand_a           = directed[k].operand_a;
            cmd.operand_b           = directed[k].operand_b;
            typed_res.result_value  = directed[k].want_value;
            typed_res.no_inverse    = directed[k].want_flag;
            issue_command(cmd, directed[k].typed, typed_res);
        end

        // random words, one phase per modulus
        for (k = 0; k < NUM_MODULI; k++)
        begin
            if (moduli[k] == 31'd0 && k == 6)
                write_modulus(value_t'($urandom_range(2, 32'h7fffffff)));
            else
                write_modulus(moduli[k]);
            n = (cur_modulus < 2) ? 12 : 41;
            repeat (n)
            begin
                cmd = random_command(cur_modulus);
                issue_command(cmd, 1'b0, '0);
            end
        end

        // drain and settle
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        any_fail = (mismatches != 0) || (pending_results.size() != 0);
        if (!any_fail)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
